FILE: rtl/core/lspg_pkg.sv
`default_nettype none
package lspg_pkg;

  // Table geometry, fixed by the widths of lit_index, byte_pos and lit_length
  localparam int NUM_LITS = 32;
  localparam int LIT_MAX  = 16;

  typedef enum logic [2:0] {
    OP_LIT_HDR  = 3'd0,
    OP_LIT_BYTE = 3'd1,
    OP_SCAN     = 3'd2,
    OP_END      = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  localparam logic [1:0] CFG_CASE_FOLD = 2'd0;
  localparam logic [1:0] CFG_ALT_COUNT = 2'd1;

  // Controller to datapath
  typedef struct packed {
    logic lit_hdr;
    logic lit_byte;
    logic scan_start;
    logic scan_step;
    logic scan_last;
    logic gate_start;
    logic gate_step;
    logic flush;
    logic clear_tab;
  } lspg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic gate_pass;
  } lspg_sts_t;

  function automatic logic [7:0] fold_byte(input logic fold, input logic [7:0] c);
    if (fold && c >= 8'h41 && c <= 8'h5a) return c + 8'd32;
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/lspg_ctrl.sv
`default_nettype none
module lspg_ctrl #(
  parameter int NUM_ALTS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [2:0]          op,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     pass,
  output lspg_pkg::lspg_cmd_t      cmd,
  input  wire lspg_pkg::lspg_sts_t sts
);
  localparam int NUM_LITS = lspg_pkg::NUM_LITS;
  localparam int LW = (NUM_LITS > 1) ? $clog2(NUM_LITS) : 1;
  localparam int AW = (NUM_ALTS > 1) ? $clog2(NUM_ALTS) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_GATE = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t        state;
  logic [LW-1:0] cnt;
  logic [AW-1:0] acnt;
  logic          acc;

  assign acc      = in_valid && in_ready;
  // Hold input while a scan or gate pass runs or the result waits.
  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    cmd.lit_hdr    = acc && (op == lspg_pkg::OP_LIT_HDR);
    cmd.lit_byte   = acc && (op == lspg_pkg::OP_LIT_BYTE);
    cmd.scan_start = acc && (op == lspg_pkg::OP_SCAN);
    cmd.gate_start = acc && (op == lspg_pkg::OP_END);
    cmd.clear_tab  = acc && (op == lspg_pkg::OP_CLEAR);
    cmd.scan_step  = (state == S_SCAN);
    cmd.scan_last  = (state == S_SCAN) && (cnt == LW'(NUM_LITS - 1));
    cmd.gate_step  = (state == S_GATE);
    cmd.flush      = (state == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      acnt      <= '0;
      out_valid <= 1'b0;
      pass      <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          cnt  <= '0;
          acnt <= '0;
          if (cmd.scan_start) state <= S_SCAN;
          if (cmd.gate_start) state <= S_GATE;
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cmd.scan_last) state <= S_IDLE;
        end
        S_GATE: begin
          acnt <= acnt + 1'b1;
          if (acnt == AW'(NUM_ALTS - 1)) state <= S_DONE;
        end
        S_DONE: begin
          pass      <= sts.gate_pass;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/lspg_dp.sv
`default_nettype none
module lspg_dp #(
  parameter int NUM_ALTS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [5:0]          cfg_data,
  input  wire logic [4:0]          lit_index,
  input  wire logic [4:0]          alt_index,
  input  wire logic [4:0]          lit_length,
  input  wire logic [3:0]          byte_pos,
  input  wire logic [7:0]          data_byte,
  input  wire lspg_pkg::lspg_cmd_t cmd,
  output lspg_pkg::lspg_sts_t      sts
);
  localparam int NUM_LITS = lspg_pkg::NUM_LITS;
  localparam int LIT_MAX  = lspg_pkg::LIT_MAX;
  localparam int LW = (NUM_LITS > 1) ? $clog2(NUM_LITS) : 1;
  localparam int PW = (LIT_MAX > 1) ? $clog2(LIT_MAX) : 1;
  localparam int AW = (NUM_ALTS > 1) ? $clog2(NUM_ALTS) : 1;
  localparam int NW = $clog2(LIT_MAX + 1);

  logic                 case_fold;
  logic [5:0]           alt_count;
  // One row of literal bytes per table entry, byte k at bits 8k+7..8k
  logic [LIT_MAX*8-1:0] bytes_mem [NUM_LITS];
  logic [4:0]           len_r     [NUM_LITS];
  logic [4:0]           alt_r     [NUM_LITS];
  logic [NUM_LITS-1:0]  valid;
  logic [NUM_LITS-1:0]  found;
  logic [7:0]           win       [LIT_MAX];
  logic [NW-1:0]        seen;
  logic [LW-1:0]        se;
  logic [AW-1:0]        ga;
  logic                 gpass;
  logic                 cur_match;
  logic                 alt_ok;
  logic [NW-1:0]        len_n;
  logic                 idx_ok;
  logic                 pos_ok;

  assign cfg_ready = 1'b1;
  assign idx_ok = (32'(lit_index) < NUM_LITS);
  assign pos_ok = (32'(byte_pos) < LIT_MAX);
  assign sts.gate_pass = gpass;

  // Compare one table entry per cycle against the window.
  always_comb begin
    len_n = NW'(len_r[se]);
    cur_match = valid[se] && !found[se] && (len_r[se] != 5'd0) &&
                (32'(len_r[se]) <= LIT_MAX) && (len_n <= seen);
    for (int k = 0; k < LIT_MAX; k++) begin
      if (k < 32'(len_r[se]) &&
          lspg_pkg::fold_byte(case_fold, bytes_mem[se][k*8 +: 8]) !=
          lspg_pkg::fold_byte(case_fold, win[LIT_MAX - 32'(len_r[se]) + k]))
        cur_match = 1'b0;
    end
  end

  // Alternative ga passes if no valid literal of it is unfound.
  always_comb begin
    alt_ok = 1'b1;
    for (int e = 0; e < NUM_LITS; e++)
      if (valid[e] && alt_r[e] == 5'(ga) && !found[e]) alt_ok = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.lit_hdr && idx_ok) begin
      len_r[lit_index[LW-1:0]] <= lit_length;
      alt_r[lit_index[LW-1:0]] <= alt_index;
    end
    if (cmd.lit_byte && idx_ok && pos_ok)
      bytes_mem[lit_index[LW-1:0]][byte_pos[PW-1:0]*8 +: 8] <= data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      case_fold <= 1'b0;
      alt_count <= '0;
      valid     <= '0;
      found     <= '0;
      seen      <= '0;
      se        <= '0;
      ga        <= '0;
      gpass     <= 1'b0;
      for (int i = 0; i < LIT_MAX; i++) win[i] <= 8'd0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == lspg_pkg::CFG_CASE_FOLD) case_fold <= cfg_data[0];
        if (cfg_index == lspg_pkg::CFG_ALT_COUNT) alt_count <= cfg_data;
      end
      if (cmd.lit_hdr && idx_ok) begin
        valid[lit_index[LW-1:0]] <= (lit_length != 5'd0) &&
            (32'(lit_length) <= LIT_MAX) && (32'(alt_index) < NUM_ALTS);
        found[lit_index[LW-1:0]] <= 1'b0;
      end
      if (cmd.lit_byte && idx_ok && pos_ok) found[lit_index[LW-1:0]] <= 1'b0;
      if (cmd.scan_start) begin
        for (int i = 0; i < LIT_MAX - 1; i++) win[i] <= win[i+1];
        win[LIT_MAX-1] <= data_byte;
        if (seen != NW'(LIT_MAX)) seen <= seen + 1'b1;
        se <= '0;
      end
      if (cmd.scan_step) begin
        if (cur_match) found[se] <= 1'b1;
        se <= se + 1'b1;
      end
      if (cmd.gate_start) begin
        ga    <= '0;
        gpass <= (alt_count == 6'd0);
      end
      if (cmd.gate_step) begin
        if (32'(ga) < 32'(alt_count) && alt_ok) gpass <= 1'b1;
        ga <= ga + 1'b1;
      end
      if (cmd.flush) begin
        found <= '0;
        seen  <= '0;
        for (int i = 0; i < LIT_MAX; i++) win[i] <= 8'd0;
      end
      if (cmd.clear_tab) begin
        valid <= '0;
        found <= '0;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/literal_set_presence_gate_core.sv
`default_nettype none
// Channel | Direction | Handshake              | Word
// input   | in        | in_valid / in_ready    | op, lit_index, alt_index, lit_length,
//         |           |                        | byte_pos, data_byte
// output  | out       | out_valid / out_ready  | pass
// config  | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Table ops and clear are written as they are accepted. For a scan byte, one shared comparator
// walks the literal table one entry per cycle, and input stalls until the walk ends.
// At end of buffer, one alternative is checked per cycle, then the result is registered.
// Reset (rst, synchronous) clears marks, window and registers; no clearing pass.
// Input stalls while a result waits on out_ready.
module literal_set_presence_gate_core #(
  parameter int NUM_ALTS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] op,
  input  wire logic [4:0] lit_index,
  input  wire logic [4:0] alt_index,
  input  wire logic [4:0] lit_length,
  input  wire logic [3:0] byte_pos,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            pass,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [5:0] cfg_data
);
  lspg_pkg::lspg_cmd_t cmd;
  lspg_pkg::lspg_sts_t sts;

  // Sequence each word through the datapath.
  lspg_ctrl #(.NUM_ALTS(NUM_ALTS)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .op, .out_valid, .out_ready, .pass,
    .cmd, .sts
  );

  // Hold table, window and marks; compare and evaluate.
  lspg_dp #(.NUM_ALTS(NUM_ALTS)) u_dp (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .lit_index,
    .alt_index, .lit_length, .byte_pos, .data_byte, .cmd, .sts
  );
endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int N_LITS = 32;
  localparam int L_MAX  = 16;
  localparam int N_ALTS = 32;
  localparam int LIMIT  = 400000;

  // Gate predictor: literal table, found marks and byte window, updated per accepted word.
  class gate_scoreboard;
    logic [7:0] lbytes [N_LITS][L_MAX];
    logic [4:0] llen   [N_LITS];
    logic [4:0] lalt   [N_LITS];
    bit         lvalid [N_LITS];
    bit         lfound [N_LITS];
    logic [7:0] window [L_MAX];
    int         seen;
    bit         fold;
    int         alts;
    bit         pass_q[$];
    int         errors;

    function void clear_run();
      foreach (lfound[e]) lfound[e] = 0;
      foreach (window[k]) window[k] = 8'h00;
      seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [5:0] val);
      if (idx == lspg_pkg::CFG_CASE_FOLD) fold = val[0];
      else if (idx == lspg_pkg::CFG_ALT_COUNT) alts = val;
    endfunction

    function logic [7:0] folded(logic [7:0] c);
      if (fold && c >= "A" && c <= "Z") return c + 8'd32;
      return c;
    endfunction

    function bit ends_here(int e);
      int n;
      n = llen[e];
      if (n == 0 || n > L_MAX || n > seen) return 0;
      for (int k = 0; k < n; k++)
        if (folded(lbytes[e][k]) != folded(window[L_MAX - n + k])) return 0;
      return 1;
    endfunction

    function bit gate_result();
      int used;
      bit all;
      used = (alts > N_ALTS) ? N_ALTS : alts;
      if (used == 0) return 1;
      for (int a = 0; a < used; a++) begin
        all = 1;
        for (int e = 0; e < N_LITS; e++)
          if (lvalid[e] && lalt[e] == a && !lfound[e]) all = 0;
        if (all) return 1;
      end
      return 0;
    endfunction

    function void note_word(logic [2:0] o, logic [4:0] li, logic [4:0] ai, logic [4:0] ln,
                            logic [3:0] bp, logic [7:0] db);
      case (o)
        lspg_pkg::OP_LIT_HDR: begin
          llen[li]   = ln;
          lalt[li]   = ai;
          lvalid[li] = (ln >= 1 && ln <= L_MAX);
          lfound[li] = 0;
        end
        lspg_pkg::OP_LIT_BYTE: begin
          lbytes[li][bp] = db;
          lfound[li] = 0;
        end
        lspg_pkg::OP_SCAN: begin
          for (int k = 0; k < L_MAX - 1; k++) window[k] = window[k + 1];
          window[L_MAX - 1] = db;
          if (seen < L_MAX) seen++;
          for (int e = 0; e < N_LITS; e++)
            if (lvalid[e] && !lfound[e] && ends_here(e)) lfound[e] = 1;
        end
        lspg_pkg::OP_END: begin
          pass_q.push_back(gate_result());
          clear_run();
        end
        lspg_pkg::OP_CLEAR: begin
          foreach (lvalid[e]) lvalid[e] = 0;
          foreach (lfound[e]) lfound[e] = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_pass(logic got);
      bit want;
      if (pass_q.size() == 0) begin
        $error("pass: no result expected, got %0d", got);
        errors++;
        return;
      end
      want = pass_q.pop_front();
      if (got !== want) begin
        $error("pass: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0, cfg_valid = 0;
  logic [2:0] op = '0;
  logic [4:0] lit_index = '0, alt_index = '0, lit_length = '0;
  logic [3:0] byte_pos = '0;
  logic [7:0] data_byte = '0;
  logic [1:0] cfg_index = '0;
  logic [5:0] cfg_data = '0;
  wire in_ready, out_valid, pass, cfg_ready;

  literal_set_presence_gate_core dut (.*);

  gate_scoreboard sb;
  bit quiet;     // no idling in the last part
  int cycles;
  // Shadow of which literal bytes have been written, so no unwritten byte is read.
  bit written [N_LITS][L_MAX];

  initial begin
    forever #6 clk = ~clk;
  end

  // Checker: score every result word at the edge it is accepted.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_pass(pass);
    if (!rst && in_valid && in_ready)
      sb.note_word(op, lit_index, alt_index, lit_length, byte_pos, data_byte);
  end

  // Receiver: stall in random bursts unless quiet.
  initial begin
    int gap;
    @(posedge clk);
    while (1) begin
      out_ready <= 1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        gap = $urandom_range(1, 8);
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run at a generous cycle limit.
  initial begin
    cycles = 0;
    while (1) begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // Pick a letter from the small alphabet a, A, b, B.
  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 3))
      0: return 8'h61;
      1: return 8'h41;
      2: return 8'h62;
      default: return 8'h42;
    endcase
  endfunction

  // Send one word and hold it until accepted, with an optional idle burst first.
  task automatic send_word(int o, int li, int ai, int ln, int bp, int db);
    logic [4:0] l5;
    logic [3:0] b4;
    l5 = 5'(li);
    b4 = 4'(bp);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1;
    op <= 3'(o); lit_index <= l5; alt_index <= 5'(ai); lit_length <= 5'(ln);
    byte_pos <= b4; data_byte <= 8'(db);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (o == int'(lspg_pkg::OP_LIT_BYTE)) written[l5][b4] = 1;
  endtask

  // Drop valid, drain every expected result, then allow the slowest op to finish.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pass_q.size() != 0) @(posedge clk);
    repeat (N_LITS + N_ALTS + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= 6'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.set_reg(idx, 6'(val));
  endtask

  // Load one full literal: header then every byte, so no byte goes unread.
  task automatic load_literal(int li, int alt, int n, logic [7:0] bytes [L_MAX]);
    send_word(lspg_pkg::OP_LIT_HDR, li, alt, n, 0, $urandom);
    for (int k = 0; k < n; k++)
      send_word(lspg_pkg::OP_LIT_BYTE, li, $urandom, $urandom, k, bytes[k]);
  endtask

  // A safe header never makes an entry valid with unwritten bytes.
  function automatic bit header_safe(int li, int n);
    if (n < 1 || n > L_MAX) return 1;
    for (int k = 0; k < n; k++) if (!written[li][k]) return 0;
    return 1;
  endfunction

  // Literal byte writes to a valid entry are safe; header changes are checked.
  task automatic random_word(int n_alts);
    int kind, li, n;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    li = $urandom_range(0, N_LITS - 1);
    if (kind < 55) begin
      // scan bytes mostly from a small alphabet so literals get hit
      b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : pick_letter();
      send_word(lspg_pkg::OP_SCAN, $urandom, $urandom, $urandom, $urandom, b);
    end else if (kind < 63) begin
      send_word(lspg_pkg::OP_END, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (kind < 75) begin
      n = $urandom_range(0, 31);
      if (header_safe(li, n))
        send_word(lspg_pkg::OP_LIT_HDR, li, $urandom_range(0, n_alts), n, $urandom, $urandom);
    end else if (kind < 90) begin
      b = ($urandom_range(0, 2) == 0) ? 8'($urandom) : pick_letter();
      send_word(lspg_pkg::OP_LIT_BYTE, li, $urandom, $urandom, $urandom, b);
    end else if (kind < 93) begin
      send_word(lspg_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      send_word($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    logic [7:0] lit [L_MAX];
    int n;
    sb = new();
    sb.errors = 0;
    sb.fold = 0;
    sb.alts = 0;
    sb.clear_run();
    foreach (sb.lvalid[e]) sb.lvalid[e] = 0;
    foreach (written[e, k]) written[e][k] = 0;
    quiet = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: alt_count zero passes, empty alternative, fold, bad headers.
    send_word(lspg_pkg::OP_END, 31, 31, 31, 15, 8'hff);
    drain();
    write_reg(lspg_pkg::CFG_ALT_COUNT, 2);
    write_reg(lspg_pkg::CFG_CASE_FOLD, 1);
    foreach (lit[k]) lit[k] = 8'(8'h41 + k);
    load_literal(0, 0, 16, lit);
    lit[0] = 8'h78; lit[1] = 8'h5a;
    load_literal(1, 1, 2, lit);
    send_word(lspg_pkg::OP_LIT_HDR, 2, 1, 0, 0, 0);   // zero length stays invalid
    send_word(lspg_pkg::OP_LIT_HDR, 3, 1, 17, 0, 0);  // too long stays invalid
    send_word(lspg_pkg::OP_SCAN, 0, 0, 0, 0, 8'h58);
    send_word(lspg_pkg::OP_SCAN, 0, 0, 0, 0, 8'h7a);
    send_word(lspg_pkg::OP_END, 0, 0, 0, 0, 0);
    for (int k = 0; k < 16; k++) send_word(lspg_pkg::OP_SCAN, 0, 0, 0, 0, 8'h61 + k);
    send_word(lspg_pkg::OP_END, 0, 0, 0, 0, 0);
    send_word(7, 31, 31, 31, 15, 8'hff);
    send_word(lspg_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
    send_word(lspg_pkg::OP_END, 0, 0, 0, 0, 0);
    drain();

    // Random phases through several register settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(lspg_pkg::CFG_CASE_FOLD, 0); write_reg(lspg_pkg::CFG_ALT_COUNT, 32);
        end
        1: begin
          write_reg(lspg_pkg::CFG_CASE_FOLD, 1); write_reg(lspg_pkg::CFG_ALT_COUNT, 63);
        end
        2: begin
          write_reg(lspg_pkg::CFG_CASE_FOLD, 0); write_reg(lspg_pkg::CFG_ALT_COUNT, 1);
        end
        3: begin
          write_reg(lspg_pkg::CFG_CASE_FOLD, 1); write_reg(lspg_pkg::CFG_ALT_COUNT, 3);
        end
        4: begin
          write_reg(lspg_pkg::CFG_CASE_FOLD, 0); write_reg(lspg_pkg::CFG_ALT_COUNT, 0);
        end
        default: begin
          write_reg(lspg_pkg::CFG_CASE_FOLD, 1); write_reg(lspg_pkg::CFG_ALT_COUNT, 4);
          quiet = 1;
        end
      endcase
      // well-formed short literals from a small alphabet, then mixed words
      for (int i = 0; i < 3; i++) begin
        n = $urandom_range(1, 3);
        foreach (lit[k]) lit[k] = pick_letter();
        load_literal($urandom_range(0, N_LITS - 1), $urandom_range(0, 4), n, lit);
      end
      for (int i = 0; i < 75; i++) random_word((ph == 0) ? 31 : 4);
      send_word(lspg_pkg::OP_END, 0, 0, 0, 0, 0);
      drain();
    end

    if (sb.errors == 0 && sb.pass_q.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule
`default_nettype wire
